>>> design/pirr_pkg.sv
// Package for the PSN indexed retransmit ring: commands, result kinds, status codes,
// config indices and the result item. No dependencies.
`timescale 1ns / 1ps
package pirr_pkg;
    localparam int RING_SIZE_DEF = 64;
    localparam int ITEM_CAP = 63;

    localparam logic [2:0] CMD_STORE = 3'd0;
    localparam logic [2:0] CMD_LIST  = 3'd1;
    localparam logic [2:0] CMD_RETX  = 3'd2;
    localparam logic [2:0] CMD_FREE  = 3'd3;
    localparam logic [2:0] CMD_AGE   = 3'd4;

    localparam logic [1:0] KIND_MISSING = 2'd0;
    localparam logic [1:0] KIND_RETX    = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INVAL = 2'd1;
    localparam logic [1:0] ST_LEN   = 2'd2;
    localparam logic [1:0] ST_TRUNC = 2'd3;

    localparam logic [1:0] CFG_MAX_LENGTH = 2'd0;
    localparam logic [1:0] CFG_MAX_AGE    = 2'd1;
    localparam logic [1:0] CFG_MAX_LOST   = 2'd2;

    // result item, packed lowest field in lowest bits
    typedef struct packed {
        logic        last;
        logic [16:0] count;
        logic        overwrote;
        logic [1:0]  status;
        logic [63:0] handle_out;
        logic [31:0] psn_out;
        logic [1:0]  kind;
    } result_t;
endpackage

>>> design/psn_indexed_retransmit_ring_unit.sv
// PSN indexed retransmit ring: a sequencer walking a ring of slots one entry at a time.
// Depends on pirr_pkg.
`timescale 1ns / 1ps
// One transaction at a time; s_tready is low from the accepting edge until the status
// item has been loaded. Store, free and unknown commands pass through accept, dispatch
// and status. List missing walks the range one PSN per cycle, stalling on a missing PSN
// while the output register is full. Retransmit first clears up to RING_SIZE older slots
// at one per cycle, then walks from the expected PSN, reading each valid slot before it
// emits it. List stops after max_lost_reg items and retransmit after 63, or either after
// RING_SIZE PSNs in a row that give nothing. Age reads and checks every slot, then
// rescans the range from both ends for new bounds. Every emitted item also waits while the
// output register is full. Each run ends with a status item (tlast). Slot payload
// memory has no reset; slot valid bits are flops. RING_SIZE must be a power of two.
module psn_indexed_retransmit_ring_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[2:0], psn[34:3], buffer_handle[98:35], length[112:99], now_ms[160:113]
    input  logic [167:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // psn_out[31:0], handle_out[95:32], status[97:96], overwrote[98], count[115:99]
    output logic [119:0] m_tdata,
    // kind[1:0]
    output logic [1:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import pirr_pkg::*;

    localparam int RING_SIZE = RING_SIZE_DEF;
    localparam int IW = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
    localparam logic [32:0] RS33 = 33'(RING_SIZE);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_LIST   = 4'd2;
    localparam logic [3:0] S_CLR    = 4'd3;
    localparam logic [3:0] S_RETX   = 4'd4;
    localparam logic [3:0] S_RRD    = 4'd5;
    localparam logic [3:0] S_AGE    = 4'd6;
    localparam logic [3:0] S_AGECK  = 4'd7;
    localparam logic [3:0] S_SCANS  = 4'd8;
    localparam logic [3:0] S_SCANE  = 4'd9;
    localparam logic [3:0] S_EMIT   = 4'd10;
    localparam logic [3:0] S_STAT   = 4'd11;
    localparam logic [3:0] S_FINAL  = 4'd12;

    // configuration
    logic [13:0] max_length_reg;
    logic [31:0] max_age_reg;
    logic [5:0]  max_lost_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= 14'd5104;
            max_age_reg    <= 32'd1000;
            max_lost_reg   <= 6'd63;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_LENGTH: max_length_reg <= cfg_data[13:0];
                CFG_MAX_AGE:    max_age_reg    <= cfg_data;
                CFG_MAX_LOST:   max_lost_reg   <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // slot storage
    logic [RING_SIZE-1:0] valid_reg;
    logic [63:0] handle_mem [RING_SIZE];
    logic [47:0] time_mem   [RING_SIZE];
    logic [63:0] rd_handle_reg;
    logic [47:0] rd_time_reg;

    // latched command
    logic [2:0]  cmd_reg;
    logic [31:0] psn_reg;
    logic [63:0] bh_reg;
    logic [13:0] len_reg;
    logic [47:0] now_reg;

    logic [3:0]  state_reg;
    logic [31:0] start_reg, end_reg;
    logic [32:0] p_reg;          // walk PSN, 33 bits to pass end at 2^32-1
    logic [32:0] left_reg;       // bounded walk count: slots left to clear, or slots scanned so far
    logic [IW:0] dry_reg;
    logic [6:0]  cnt_reg;        // emitted items
    logic [16:0] expired_reg;
    logic [1:0]  st_reg;
    logic        ov_reg;
    logic [31:0] ns_reg;

    result_t out_reg;
    logic    out_valid_reg;
    logic    out_load;

    wire [IW-1:0] pidx = p_reg[IW-1:0];
    wire          range_empty = (start_reg == 32'd0) || (start_reg > end_reg);
    wire          out_free = !out_valid_reg || m_tready;

    // age subtract/compare
    wire [47:0] age_diff = now_reg - rd_time_reg;
    wire        age_exp  = age_diff > {16'd0, max_age_reg};

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.count, out_reg.overwrote,
                       out_reg.status, out_reg.handle_out, out_reg.psn_out};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

    // memory write/read port
    logic          mem_we;
    logic [IW-1:0] mem_addr;
    always_comb
    begin
        mem_we   = (state_reg == S_DISP) && (cmd_reg == CMD_STORE) && (len_reg != 14'd0)
                   && (len_reg <= max_length_reg);
        mem_addr = (state_reg == S_DISP) ? psn_reg[IW-1:0] : pidx;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            handle_mem[mem_addr] <= bh_reg;
            time_mem[mem_addr]   <= now_reg;
        end
        rd_handle_reg <= handle_mem[mem_addr];
        rd_time_reg   <= time_mem[mem_addr];
    end

    // output register load: the states that place a transaction in out_reg
    always_comb
    begin
        unique case (state_reg)
            S_LIST:
                out_load = out_free && !valid_reg[pidx] && !(p_reg > {1'b0, end_reg}
                           || cnt_reg >= {1'b0, max_lost_reg});
            S_RETX, S_STAT:
                out_load = out_free;
            default:
                out_load = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            start_reg     <= '0;
            end_reg       <= '0;
            p_reg         <= '0;
            left_reg      <= '0;
            dry_reg       <= '0;
            cnt_reg       <= '0;
            expired_reg   <= '0;
            st_reg        <= ST_OK;
            ov_reg        <= 1'b0;
            ns_reg        <= '0;
            cmd_reg       <= '0;
            psn_reg       <= '0;
            bh_reg        <= '0;
            len_reg       <= '0;
            now_reg       <= '0;
            out_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg     <= s_tdata[2:0];
                        psn_reg     <= s_tdata[34:3];
                        bh_reg      <= s_tdata[98:35];
                        len_reg     <= s_tdata[112:99];
                        now_reg     <= s_tdata[160:113];
                        cnt_reg     <= '0;
                        expired_reg <= '0;
                        st_reg      <= ST_OK;
                        ov_reg      <= 1'b0;
                        dry_reg     <= '0;
                        state_reg   <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    state_reg <= S_STAT;
                    unique case (cmd_reg)
                        CMD_STORE:
                        begin
                            if (len_reg == 14'd0)
                                st_reg <= ST_INVAL;
                            else if (len_reg > max_length_reg)
                                st_reg <= ST_LEN;
                            else
                            begin
                                ov_reg <= valid_reg[psn_reg[IW-1:0]];
                                valid_reg[psn_reg[IW-1:0]] <= 1'b1;
                                if (start_reg == 32'd0 || psn_reg < start_reg)
                                    start_reg <= psn_reg;
                                if (psn_reg > end_reg)
                                    end_reg <= psn_reg;
                            end
                        end
                        CMD_LIST:
                        begin
                            if (max_lost_reg == 6'd0)
                                st_reg <= ST_INVAL;
                            else if (!range_empty)
                            begin
                                p_reg     <= {1'b0, start_reg};
                                state_reg <= S_LIST;
                            end
                        end
                        CMD_RETX:
                        begin
                            if (psn_reg == 32'd0)
                                st_reg <= ST_INVAL;
                            else if (!range_empty)
                            begin
                                p_reg <= {1'b0, start_reg};
                                // cleared span: min(epsn-1,end) - start + 1, capped
                                if (start_reg < psn_reg)
                                begin
                                    left_reg  <= {1'b0, (psn_reg - 32'd1 > end_reg)
                                                 ? end_reg : psn_reg - 32'd1} -
                                                 {1'b0, start_reg} + 33'd1;
                                    state_reg <= S_CLR;
                                end
                                else
                                begin
                                    p_reg     <= {1'b0, psn_reg};
                                    state_reg <= S_RRD;
                                end
                            end
                        end
                        CMD_FREE: valid_reg[psn_reg[IW-1:0]] <= 1'b0;
                        CMD_AGE:
                        begin
                            p_reg     <= '0;
                            state_reg <= S_AGE;
                        end
                        default: st_reg <= ST_INVAL;
                    endcase
                end
                // list missing: one PSN per cycle, holding on a missing PSN while the output is full
                S_LIST:
                begin
                    if (p_reg > {1'b0, end_reg} || cnt_reg >= {1'b0, max_lost_reg})
                        state_reg <= S_STAT;
                    else if (!valid_reg[pidx])
                    begin
                        if (out_free)
                        begin
                            out_reg       <= '{last: 1'b0, count: '0, overwrote: 1'b0,
                                               status: ST_OK, handle_out: '0,
                                               psn_out: p_reg[31:0], kind: KIND_MISSING};
                            cnt_reg       <= cnt_reg + 7'd1;
                            dry_reg       <= '0;
                            p_reg         <= p_reg + 33'd1;
                        end
                    end
                    else if ({1'b0, dry_reg} + 1 >= RING_SIZE)
                        state_reg <= S_STAT;
                    else
                    begin
                        dry_reg <= dry_reg + 1'b1;
                        p_reg   <= p_reg + 33'd1;
                    end
                end
                // retransmit: clear older slots, at most one ring's worth
                S_CLR:
                begin
                    if (left_reg == 33'd0 || (p_reg - {1'b0, start_reg}) >= RS33)
                    begin
                        p_reg     <= {1'b0, psn_reg};
                        state_reg <= S_RRD;
                    end
                    else
                    begin
                        valid_reg[pidx] <= 1'b0;
                        p_reg    <= p_reg + 33'd1;
                        left_reg <= left_reg - 33'd1;
                    end
                end
                // memory read issued at pidx; data next cycle
                S_RRD:
                begin
                    if (p_reg > {1'b0, end_reg})
                        state_reg <= S_FINAL;
                    else if (valid_reg[pidx])
                    begin
                        if (cnt_reg >= 7'(ITEM_CAP))
                        begin
                            st_reg    <= ST_TRUNC;
                            state_reg <= S_FINAL;
                        end
                        else
                            state_reg <= S_RETX;
                    end
                    else if ({1'b0, dry_reg} + 1 >= RING_SIZE)
                        state_reg <= S_FINAL;
                    else
                    begin
                        dry_reg <= dry_reg + 1'b1;
                        p_reg   <= p_reg + 33'd1;
                    end
                end
                S_RETX:
                begin
                    if (out_free)
                    begin
                        out_reg       <= '{last: 1'b0, count: '0, overwrote: 1'b0,
                                           status: ST_OK, handle_out: rd_handle_reg,
                                           psn_out: p_reg[31:0], kind: KIND_RETX};
                        cnt_reg       <= cnt_reg + 7'd1;
                        dry_reg       <= '0;
                        p_reg         <= p_reg + 33'd1;
                        state_reg     <= S_RRD;
                    end
                end
                // age: read slot time, then compare
                S_AGE:
                begin
                    if (p_reg >= RS33)
                    begin
                        if (expired_reg == 17'd0 || start_reg > end_reg)
                        begin
                            if (expired_reg != 17'd0)
                            begin
                                start_reg <= '0;
                                end_reg   <= '0;
                            end
                            state_reg <= S_STAT;
                        end
                        else
                        begin
                            p_reg    <= {1'b0, start_reg};
                            left_reg <= '0;
                            state_reg <= S_SCANS;
                        end
                    end
                    else
                        state_reg <= S_AGECK;
                end
                S_AGECK:
                begin
                    if (valid_reg[pidx] && age_exp)
                    begin
                        valid_reg[pidx] <= 1'b0;
                        expired_reg     <= expired_reg + 17'd1;
                    end
                    p_reg     <= p_reg + 33'd1;
                    state_reg <= S_AGE;
                end
                // rescan range from the start, up to min(total, RING_SIZE)
                S_SCANS:
                begin
                    if (left_reg >= RS33 || p_reg > {1'b0, end_reg})
                    begin
                        start_reg <= '0;
                        end_reg   <= '0;
                        state_reg <= S_STAT;
                    end
                    else if (valid_reg[pidx])
                    begin
                        ns_reg    <= p_reg[31:0];
                        p_reg     <= {1'b0, end_reg};
                        state_reg <= S_SCANE;
                    end
                    else
                    begin
                        p_reg    <= p_reg + 33'd1;
                        left_reg <= left_reg + 33'd1;
                    end
                end
                S_SCANE:
                begin
                    if (valid_reg[pidx])
                    begin
                        start_reg <= ns_reg;
                        end_reg   <= p_reg[31:0];
                        state_reg <= S_STAT;
                    end
                    else
                        p_reg <= p_reg - 33'd1;
                end
                // retransmit range update
                S_FINAL:
                begin
                    if (psn_reg > end_reg)
                    begin
                        start_reg <= '0;
                        end_reg   <= '0;
                    end
                    else
                        start_reg <= psn_reg;
                    state_reg <= S_STAT;
                end
                S_STAT:
                begin
                    if (out_free)
                    begin
                        out_reg       <= '{last: 1'b1,
                                           count: (cmd_reg == CMD_AGE) ? expired_reg
                                                  : {10'd0, cnt_reg},
                                           overwrote: ov_reg, status: st_reg,
                                           handle_out: '0, psn_out: '0,
                                           kind: KIND_STATUS};
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // assertions
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("ready while busy");
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 7'(ITEM_CAP))
        else $error("item count over cap");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped");
    a_stat_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == KIND_STATUS)))
        else $error("last flag does not match status kind");
endmodule
